// ===== sv/rrlt_pkg.sv =====
package rrlt_pkg;

	// Table geometry and coordinate width.
	localparam int TABLE_DEPTH = 64;
	localparam int COORD_BITS  = 16;
	localparam int IDX_BITS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int ID_BITS     = 32;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [IDX_BITS-1:0]   idx_t;
	typedef logic [IDX_BITS:0]     cnt_t;
	typedef logic [ID_BITS-1:0]    ident_t;

	// Operation codes of an input item.
	typedef enum logic {
		OP_LOCK    = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	// Result status codes.
	typedef enum logic [2:0] {
		STAT_GRANTED   = 3'd0,
		STAT_CONFLICT  = 3'd1,
		STAT_FULL      = 3'd2,
		STAT_RELEASED  = 3'd3,
		STAT_NOT_FOUND = 3'd4
	} status_t;

	// One table entry as it is stored in the memory.
	typedef struct packed {
		coord_t left;
		coord_t top;
		coord_t right;
		coord_t bottom;
		logic   excl;
		ident_t ident;
	} entry_t;

	localparam int ENTRY_BITS = $bits(entry_t);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// Closed-interval overlap on both axes.
	function automatic logic rect_overlap(entry_t a, entry_t b);
		return (a.left <= b.right) && (b.left <= a.right) &&
			(a.top <= b.bottom) && (b.top <= a.bottom);
	endfunction

endpackage

// ===== sv/rrlt_req_if.sv =====
interface rrlt_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [15:0] x_left;
	logic [15:0] y_top;
	logic [15:0] x_right;
	logic [15:0] y_bottom;
	logic        exclusive;
	logic [31:0] release_id;

	modport source (
		output valid, operation, x_left, y_top, x_right, y_bottom, exclusive, release_id,
		input  ready
	);
	modport sink (
		input  valid, operation, x_left, y_top, x_right, y_bottom, exclusive, release_id,
		output ready
	);
endinterface

// ===== sv/rrlt_rsp_if.sv =====
interface rrlt_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] granted_id;

	modport source (
		output valid, status, granted_id,
		input  ready
	);
	modport sink (
		input  valid, status, granted_id,
		output ready
	);
endinterface

// ===== sv/rrlt_ram.sv =====
// Single-port-write, single-port-read RAM with registered read data.
module rrlt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/rectangle_rw_lock_table.sv =====
// Rectangle reader/writer lock table. Each item is either a lock request for
// a rectangle (shared or exclusive) or a release by id, and each item gives
// exactly one result item with a status and, on a grant, the new lock id.
// Entries live in one RAM with a registered read; a valid bit per entry is
// held in flip-flops and cleared by reset, so no clearing pass is needed.
// Every item sweeps the whole table through the RAM read port, one entry per
// cycle, and the next item is accepted in the cycle after the result is
// loaded, even while that result still waits on the output. A request
// conflicts when it overlaps a held lock and either side is exclusive; the
// conflict check wins over a full table. Ids count up from one, wrap to one
// and never take the value zero.
module rectangle_rw_lock_table (
	input logic        clk,
	input logic        arst_n,
	rrlt_req_if.sink   req,
	rrlt_rsp_if.source rsp
);

	// Captured item.
	rrlt_pkg::op_t    op_q;
	rrlt_pkg::entry_t rect_q;
	rrlt_pkg::ident_t rid_q;

	// Control.
	rrlt_pkg::state_t state_q, state_d;
	rrlt_pkg::cnt_t   issue_cnt_q;
	logic             rd_vld_s1;
	rrlt_pkg::idx_t   idx_s1;

	// Scan results.
	logic             conflict_q;
	logic             have_free_q;
	rrlt_pkg::idx_t   free_idx_q;
	logic             found_q;
	rrlt_pkg::idx_t   found_idx_q;

	// Table state outside the RAM.
	logic [rrlt_pkg::TABLE_DEPTH-1:0] valid_q;
	rrlt_pkg::ident_t                 next_id_q;

	// Output register.
	logic                out_valid_q;
	rrlt_pkg::status_t   out_status_q;
	rrlt_pkg::ident_t    out_gid_q;

	// Combinational control.
	logic             accept;
	logic             issue;
	logic             scan_done;
	logic             out_free;
	logic             finish;
	logic             ram_we;
	rrlt_pkg::idx_t   ram_raddr;
	rrlt_pkg::entry_t ram_rdata;
	rrlt_pkg::entry_t ram_wdata;
	logic             grant;
	rrlt_pkg::status_t res_status;

	rrlt_ram #(
		.WIDTH(rrlt_pkg::ENTRY_BITS),
		.DEPTH(rrlt_pkg::TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(free_idx_q),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign out_free  = !out_valid_q || rsp.ready;
	assign issue     = (state_q == rrlt_pkg::ST_SCAN) &&
		(issue_cnt_q != rrlt_pkg::cnt_t'(rrlt_pkg::TABLE_DEPTH));
	assign scan_done = (state_q == rrlt_pkg::ST_SCAN) && !issue && !rd_vld_s1;
	assign ram_raddr = issue_cnt_q[rrlt_pkg::IDX_BITS-1:0];

	// A grant happens only for a lock request with no conflict and a free slot.
	assign grant = (op_q == rrlt_pkg::OP_LOCK) && !conflict_q && have_free_q;

	always_comb begin
		ram_wdata       = rect_q;
		ram_wdata.ident = next_id_q;
	end

	always_comb begin
		if (op_q == rrlt_pkg::OP_LOCK) begin
			if (conflict_q) begin
				res_status = rrlt_pkg::STAT_CONFLICT;
			end else if (!have_free_q) begin
				res_status = rrlt_pkg::STAT_FULL;
			end else begin
				res_status = rrlt_pkg::STAT_GRANTED;
			end
		end else begin
			res_status = found_q ? rrlt_pkg::STAT_RELEASED : rrlt_pkg::STAT_NOT_FOUND;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rrlt_pkg::ST_IDLE: begin
				if (req.valid) begin
					state_d = rrlt_pkg::ST_SCAN;
				end
			end
			rrlt_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = rrlt_pkg::ST_FINISH;
				end
			end
			rrlt_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = rrlt_pkg::ST_IDLE;
				end
			end
			default: state_d = rrlt_pkg::ST_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		req.ready = 1'b0;
		finish    = 1'b0;
		unique case (state_q)
			rrlt_pkg::ST_IDLE:   req.ready = 1'b1;
			rrlt_pkg::ST_SCAN:   ;
			rrlt_pkg::ST_FINISH: finish = out_free;
			default:             ;
		endcase
	end

	assign accept = req.valid && req.ready;
	assign ram_we = finish && grant;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rrlt_pkg::ST_IDLE;
			issue_cnt_q <= '0;
			rd_vld_s1   <= 1'b0;
			valid_q     <= '0;
			next_id_q   <= rrlt_pkg::ident_t'(1);
			out_valid_q <= 1'b0;
			conflict_q  <= 1'b0;
			have_free_q <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (accept) begin
				issue_cnt_q <= '0;
				conflict_q  <= 1'b0;
				have_free_q <= 1'b0;
				found_q     <= 1'b0;
			end else if (issue) begin
				issue_cnt_q <= issue_cnt_q + rrlt_pkg::cnt_t'(1);
			end

			// Evaluate the entry whose RAM read was issued in the previous cycle.
			if (rd_vld_s1) begin
				if (valid_q[idx_s1]) begin
					if ((rect_q.excl || ram_rdata.excl) &&
						rrlt_pkg::rect_overlap(ram_rdata, rect_q)) begin
						conflict_q <= 1'b1;
					end
					if (!found_q && (ram_rdata.ident == rid_q)) begin
						found_q <= 1'b1;
					end
				end else if (!have_free_q) begin
					have_free_q <= 1'b1;
				end
			end

			if (finish) begin
				if (grant) begin
					valid_q[free_idx_q] <= 1'b1;
					next_id_q <= (next_id_q == '1) ? rrlt_pkg::ident_t'(1)
						: next_id_q + rrlt_pkg::ident_t'(1);
				end else if ((op_q == rrlt_pkg::OP_RELEASE) && found_q) begin
					valid_q[found_idx_q] <= 1'b0;
				end
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		idx_s1 <= ram_raddr;
		if (accept) begin
			op_q        <= rrlt_pkg::op_t'(req.operation);
			rect_q.left   <= rrlt_pkg::COORD_BITS'(req.x_left);
			rect_q.top    <= rrlt_pkg::COORD_BITS'(req.y_top);
			rect_q.right  <= rrlt_pkg::COORD_BITS'(req.x_right);
			rect_q.bottom <= rrlt_pkg::COORD_BITS'(req.y_bottom);
			rect_q.excl   <= req.exclusive;
			rect_q.ident  <= '0;
			rid_q       <= req.release_id;
		end
		if (rd_vld_s1) begin
			if (valid_q[idx_s1]) begin
				if (!found_q && (ram_rdata.ident == rid_q)) begin
					found_idx_q <= idx_s1;
				end
			end else if (!have_free_q) begin
				free_idx_q <= idx_s1;
			end
		end
		if (finish) begin
			out_status_q <= res_status;
			out_gid_q    <= grant ? next_id_q : '0;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.granted_id = out_gid_q;

endmodule

// ===== sv/rrlt_checker.sv =====
module rrlt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [2:0]  rsp_status,
	input logic [31:0] rsp_granted_id
);

	// A result that is not taken stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result withdrawn before it was taken");

	// The table works on one item at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("item accepted while the previous one is still in work");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status == rrlt_pkg::STAT_GRANTED) ||
			(rsp_status == rrlt_pkg::STAT_CONFLICT) ||
			(rsp_status == rrlt_pkg::STAT_FULL) ||
			(rsp_status == rrlt_pkg::STAT_RELEASED) ||
			(rsp_status == rrlt_pkg::STAT_NOT_FOUND))
		else $error("result status is not a defined code");

	a_grant_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == rrlt_pkg::STAT_GRANTED) |-> (rsp_granted_id != '0))
		else $error("grant carries id zero");

	a_other_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != rrlt_pkg::STAT_GRANTED) |-> (rsp_granted_id == '0))
		else $error("non-grant result carries an id");

endmodule

bind rectangle_rw_lock_table rrlt_checker u_rrlt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_status    (rsp.status),
	.rsp_granted_id(rsp.granted_id)
);
